// ===== rtl/assert_macros.svh =====
// Assertion macros used by the jitter ring FIFO top module.
// Each macro checks on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in every cycle.
`define AJRF_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define AJRF_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define AJRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ajrf_pkg.sv =====
// Package of the audio jitter ring FIFO: sizes, field types, codes and helpers.
// Used by the channel interfaces, the top module and the testbench; depends on nothing.
package ajrf_pkg;

   localparam int DEPTH    = 1024;
   localparam int PTR_W    = $clog2(DEPTH);
   localparam int LEVEL_W  = $clog2(DEPTH + 1);
   localparam int SAMPLE_W = 16;
   localparam int LEN_W    = 16;
   localparam int CMP_W    = LEN_W + 1;
   localparam int COUNT_W  = 32;

   typedef logic [PTR_W-1:0]    ptr_type;
   typedef logic [LEVEL_W-1:0]  level_type;
   typedef logic [CMP_W-1:0]    cmp_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [SAMPLE_W-1:0] sample_type;

   localparam ptr_type   PTR_LAST    = ptr_type'(DEPTH - 1);
   localparam level_type LEVEL_FULL  = level_type'(DEPTH);
   localparam cmp_type   DEPTH_CMP   = cmp_type'(DEPTH);

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_TUNE = 2'd2,
      OP_NOP  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_REJECT   = 2'd1,
      STAT_UNDERRUN = 2'd2
   } status_type;

   // Everything about one result except the popped sample, which arrives
   // from the sample memory in the next cycle.
   typedef struct packed {
      logic       deliver;
      status_type status;
      level_type  fill_level;
      count_type  overrun_total;
      count_type  underrun_total;
      level_type  min_level;
      level_type  max_level;
   } pend_type;

   function automatic ptr_type ptr_next(input ptr_type p);
      ptr_type n;
      if (p == PTR_LAST) begin
         n = '0;
      end else begin
         n = p + ptr_type'(1);
      end
      return n;
   endfunction

endpackage

// ===== rtl/ajrf_req_if.sv =====
// Request channel of the jitter ring FIFO: valid/ready handshake and one input item.
// Depends on ajrf_pkg for field widths.
interface ajrf_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        opcode;
   logic signed [ajrf_pkg::SAMPLE_W-1:0] sample_in;
   logic [ajrf_pkg::LEN_W-1:0]        frame_len;
   logic                              frame_first;

   modport source (output valid, opcode, sample_in, frame_len, frame_first, input ready);
   modport sink   (input valid, opcode, sample_in, frame_len, frame_first, output ready);
endinterface

// ===== rtl/ajrf_rsp_if.sv =====
// Response channel of the jitter ring FIFO: valid/ready handshake and one result item.
// Depends on ajrf_pkg for field widths.
interface ajrf_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ajrf_pkg::SAMPLE_W-1:0] sample_out;
   logic [1:0]                           status;
   logic [ajrf_pkg::LEVEL_W-1:0]         fill_level;
   logic [ajrf_pkg::COUNT_W-1:0]         overrun_total;
   logic [ajrf_pkg::COUNT_W-1:0]         underrun_total;
   logic [ajrf_pkg::LEVEL_W-1:0]         min_level;
   logic [ajrf_pkg::LEVEL_W-1:0]         max_level;

   modport source (output valid, sample_out, status, fill_level, overrun_total,
                   underrun_total, min_level, max_level, input ready);
   modport sink   (input valid, sample_out, status, fill_level, overrun_total,
                   underrun_total, min_level, max_level, output ready);
endinterface

// ===== rtl/ajrf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Self-contained; no package dependency.
module ajrf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/audio_jitter_ring_fifo.sv =====
// Top level of the audio jitter ring FIFO: control, counters and result register.
// Depends on ajrf_pkg, ajrf_req_if, ajrf_rsp_if, ajrf_ram and assert_macros.svh.
//
//   channel   direction  handshake        payload
//   req_chan  in         valid / ready    opcode, sample_in, frame_len, frame_first
//   rsp_chan  out        valid / ready    sample_out, status, fill_level, overrun_total,
//                                         underrun_total, min_level, max_level
//   csr_*     in         write enable     tune_enable (1 bit)
//
// One item is accepted per cycle when the result side keeps up; its result
// goes through the pending stage, which waits for the registered read of the
// sample memory, and the output register. Reset is synchronous and needs no
// clearing pass: the sample memory is only read at entries written before.
// When the result is not taken, one finished result waits in the output
// register and one more item in the pending stage; then requests are held off.
`include "assert_macros.svh"

module audio_jitter_ring_fifo (
   input  logic clock,
   input  logic reset,
   ajrf_req_if.sink   req_chan,
   ajrf_rsp_if.source rsp_chan,
   input  logic csr_write_enable,
   input  logic csr_write_data
);

   // Architectural state. The pointers, level and frame flags change on the
   // edge an item is accepted, so the next item always sees current values.
   ajrf_pkg::ptr_type   wr_ptr_ff, wr_ptr_in;
   ajrf_pkg::ptr_type   rd_ptr_ff, rd_ptr_in;
   ajrf_pkg::level_type level_ff, level_in;
   ajrf_pkg::count_type overrun_ff, overrun_in;
   ajrf_pkg::count_type underrun_ff, underrun_in;
   ajrf_pkg::level_type min_ff, min_in;
   ajrf_pkg::level_type max_ff, max_in;
   logic rejected_ff, rejected_in;
   logic overflowed_ff, overflowed_in;
   logic starved_ff, starved_in;
   logic tune_en_ff;

   // Pending stage: waits for the memory read, then moves to the output register.
   logic               pend_valid_ff;
   ajrf_pkg::pend_type pend_ff, pend_in;

   // Output register.
   logic                      rsp_valid_ff;
   ajrf_pkg::sample_type      rsp_sample_ff;
   ajrf_pkg::status_type      rsp_status_ff;
   ajrf_pkg::level_type       rsp_level_ff;
   ajrf_pkg::count_type       rsp_overrun_ff;
   ajrf_pkg::count_type       rsp_underrun_ff;
   ajrf_pkg::level_type       rsp_min_ff;
   ajrf_pkg::level_type       rsp_max_ff;

   logic                 ram_we;
   logic                 ram_re;
   ajrf_pkg::sample_type ram_rd_data;

   logic               pend_move;
   logic               req_fire;
   ajrf_pkg::op_type   op;
   ajrf_pkg::cmp_type  len_cmp;
   ajrf_pkg::cmp_type  level_cmp;

   // The pending item leaves when the output register is free or being emptied;
   // a new item may enter the pending stage on the same edge.
   assign pend_move      = pend_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !reset && (!pend_valid_ff || pend_move);
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign op        = ajrf_pkg::op_type'(req_chan.opcode);
   assign len_cmp   = ajrf_pkg::cmp_type'(req_chan.frame_len);
   assign level_cmp = ajrf_pkg::cmp_type'(level_ff);

   always_comb begin
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      level_in      = level_ff;
      overrun_in    = overrun_ff;
      underrun_in   = underrun_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      rejected_in   = rejected_ff;
      overflowed_in = overflowed_ff;
      starved_in    = starved_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      pend_in       = '0;
      pend_in.status = ajrf_pkg::STAT_OK;

      if (req_fire) begin
         unique case (op)
            ajrf_pkg::OP_PUSH: begin
               if (req_chan.frame_first) begin
                  rejected_in   = len_cmp > ajrf_pkg::DEPTH_CMP;
                  overflowed_in = 1'b0;
               end
               if (rejected_in) begin
                  pend_in.status = ajrf_pkg::STAT_REJECT;
               end else begin
                  // A full buffer still takes the sample and overwrites the
                  // oldest slot; the read pointer stays where it is.
                  ram_we    = 1'b1;
                  wr_ptr_in = ajrf_pkg::ptr_next(wr_ptr_ff);
                  if (level_ff >= ajrf_pkg::LEVEL_FULL) begin
                     level_in = ajrf_pkg::LEVEL_FULL;
                     if (!overflowed_in) begin
                        overrun_in    = overrun_ff + ajrf_pkg::count_type'(1);
                        overflowed_in = 1'b1;
                     end
                  end else begin
                     level_in = level_ff + ajrf_pkg::level_type'(1);
                  end
               end
            end
            ajrf_pkg::OP_POP: begin
               if (req_chan.frame_first) begin
                  starved_in = level_cmp < len_cmp;
                  if (starved_in) begin
                     underrun_in = underrun_ff + ajrf_pkg::count_type'(1);
                  end
               end
               if (starved_in || (level_ff == '0)) begin
                  pend_in.status = ajrf_pkg::STAT_UNDERRUN;
               end else begin
                  ram_re          = 1'b1;
                  pend_in.deliver = 1'b1;
                  rd_ptr_in       = ajrf_pkg::ptr_next(rd_ptr_ff);
                  level_in        = level_ff - ajrf_pkg::level_type'(1);
               end
            end
            ajrf_pkg::OP_TUNE: begin
               if (tune_en_ff) begin
                  if (level_ff > max_ff) begin
                     max_in = level_ff;
                  end
                  if (level_ff < min_ff) begin
                     min_in = level_ff;
                  end
               end
            end
            ajrf_pkg::OP_NOP: begin
            end
            default: begin
            end
         endcase
      end

      pend_in.fill_level     = level_in;
      pend_in.overrun_total  = overrun_in;
      pend_in.underrun_total = underrun_in;
      pend_in.min_level      = min_in;
      pend_in.max_level      = max_in;
   end

   ajrf_ram #(
      .WIDTH (ajrf_pkg::SAMPLE_W),
      .DEPTH (ajrf_pkg::DEPTH)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (ajrf_pkg::sample_type'(req_chan.sample_in)),
      .rd_en   (ram_re),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         level_ff      <= '0;
         overrun_ff    <= '0;
         underrun_ff   <= '0;
         min_ff        <= ajrf_pkg::LEVEL_FULL;
         max_ff        <= '0;
         rejected_ff   <= 1'b0;
         overflowed_ff <= 1'b0;
         starved_ff    <= 1'b0;
         tune_en_ff    <= 1'b1;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         level_ff      <= level_in;
         overrun_ff    <= overrun_in;
         underrun_ff   <= underrun_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         rejected_ff   <= rejected_in;
         overflowed_ff <= overflowed_in;
         starved_ff    <= starved_in;
         if (csr_write_enable) begin
            tune_en_ff <= csr_write_data;
         end
         if (req_fire) begin
            pend_valid_ff <= 1'b1;
         end else if (pend_move) begin
            pend_valid_ff <= 1'b0;
         end
         if (pend_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers. The memory data is still that of the pending item on
   // the edge it moves out, even if a new pop is issued on that same edge.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pend_ff <= pend_in;
      end
      if (pend_move) begin
         rsp_sample_ff   <= pend_ff.deliver ? ram_rd_data : '0;
         rsp_status_ff   <= pend_ff.status;
         rsp_level_ff    <= pend_ff.fill_level;
         rsp_overrun_ff  <= pend_ff.overrun_total;
         rsp_underrun_ff <= pend_ff.underrun_total;
         rsp_min_ff      <= pend_ff.min_level;
         rsp_max_ff      <= pend_ff.max_level;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.sample_out     = rsp_sample_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.fill_level     = rsp_level_ff;
   assign rsp_chan.overrun_total  = rsp_overrun_ff;
   assign rsp_chan.underrun_total = rsp_underrun_ff;
   assign rsp_chan.min_level      = rsp_min_ff;
   assign rsp_chan.max_level      = rsp_max_ff;

   `AJRF_ASSERT_ALWAYS(a_level_bound, level_ff <= ajrf_pkg::LEVEL_FULL,
      "fill level above depth")
   `AJRF_ASSERT_SAME(a_underrun_zero,
      rsp_valid_ff && (rsp_status_ff == ajrf_pkg::STAT_UNDERRUN), rsp_sample_ff == '0,
      "underrun result carries a nonzero sample")
   `AJRF_ASSERT_NEXT(a_pop_level, req_fire && ram_re,
      level_ff == $past(level_ff) - ajrf_pkg::level_type'(1),
      "delivered pop did not lower the level by one")
   `AJRF_ASSERT_NEXT(a_pend_hold, pend_valid_ff && !pend_move, pend_valid_ff,
      "pending item lost while the output was stalled")

endmodule

// ===== dv/audio_jitter_ring_fifo_test.sv =====
// Self-checking testbench for the audio jitter ring FIFO: random and directed frames,
// checked result by result against a behavioral predictor of the ring buffer.
// Depends on ajrf_pkg, ajrf_req_if, ajrf_rsp_if and the audio_jitter_ring_fifo RTL.
`timescale 1ns / 100ps

module audio_jitter_ring_fifo_test;

   // A long hold-off of the result side, used once so that the block fills up
   // and has to push back on the request side.
   localparam int HOLD_CYCLES   = 300;
   // Cycles without any handshake before the run is declared hung. The longest
   // legal quiet stretch is the hold-off above plus a few random stalls.
   localparam int STALL_LIMIT   = 3000;
   // Results trail their items; this settles the pipeline at the end.
   localparam int SETTLE_CYCLES = 20;

   typedef logic [ajrf_pkg::LEN_W-1:0] len_type;

   typedef struct {
      ajrf_pkg::op_type       opcode;
      ajrf_pkg::sample_type   sample;
      len_type                frame_len;
      logic                   frame_first;
   } audio_request_type;

   typedef struct {
      ajrf_pkg::sample_type  sample_out;
      ajrf_pkg::status_type  status;
      ajrf_pkg::level_type   fill_level;
      ajrf_pkg::count_type   overrun_total;
      ajrf_pkg::count_type   underrun_total;
      ajrf_pkg::level_type   min_level;
      ajrf_pkg::level_type   max_level;
   } audio_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable;
   logic csr_write_data;

   ajrf_req_if req_chan ();
   ajrf_rsp_if rsp_chan ();

   audio_jitter_ring_fifo uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   // Items waiting to be offered, and results that accepted items are owed.
   audio_request_type queued_requests[$];
   audio_result_type  awaited_results[$];

   int items_queued   = 0;
   int results_seen   = 0;
   int error_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int quiet_cycles   = 0;
   int hold_left      = 0;
   bit hold_arm       = 1'b0;
   bit hold_done      = 1'b0;

   // Rough fill level as seen while planning stimulus. It only steers the shape
   // of the traffic (fill, then overrun, then drain) and is never checked.
   int plan_level = 0;

   // Predicted state of the ring buffer, updated once per accepted item.
   ajrf_pkg::sample_type ring_mem [ajrf_pkg::DEPTH];
   ajrf_pkg::ptr_type    ring_wr_ptr    = '0;
   ajrf_pkg::ptr_type    ring_rd_ptr    = '0;
   int                   ring_level     = 0;
   ajrf_pkg::count_type  ring_overruns  = '0;
   ajrf_pkg::count_type  ring_underruns = '0;
   ajrf_pkg::level_type  low_mark       = ajrf_pkg::LEVEL_FULL;
   ajrf_pkg::level_type  high_mark      = '0;
   bit         push_rejected  = 1'b0;
   bit         push_overflowed = 1'b0;
   bit         pop_starved    = 1'b0;
   bit         tune_enable_copy = 1'b1;

   // Computes the result of one item and advances the predicted state. Push and
   // pop frames keep their own flags: a push frame start never touches the
   // starved flag and a pop frame start never touches the push flags.
   function automatic audio_result_type predict_ring_result(input audio_request_type item);
      audio_result_type res;
      res.sample_out = '0;
      res.status     = ajrf_pkg::STAT_OK;
      case (item.opcode)
         ajrf_pkg::OP_PUSH: begin
            if (item.frame_first) begin
               push_rejected   = int'(item.frame_len) > ajrf_pkg::DEPTH;
               push_overflowed = 1'b0;
            end
            if (push_rejected) begin
               // A frame that can never fit is dropped as a whole.
               res.status = ajrf_pkg::STAT_REJECT;
            end else begin
               ring_mem[ring_wr_ptr] = item.sample;
               ring_wr_ptr = ajrf_pkg::ptr_next(ring_wr_ptr);
               if (ring_level >= ajrf_pkg::DEPTH) begin
                  // Saturated: the oldest sample is overwritten in place, the
                  // read pointer stays, and the frame counts one overrun.
                  ring_level = ajrf_pkg::DEPTH;
                  if (!push_overflowed) begin
                     ring_overruns   = ring_overruns + ajrf_pkg::count_type'(1);
                     push_overflowed = 1'b1;
                  end
               end else begin
                  ring_level = ring_level + 1;
               end
            end
         end
         ajrf_pkg::OP_POP: begin
            if (item.frame_first) begin
               pop_starved = ring_level < int'(item.frame_len);
               if (pop_starved) begin
                  ring_underruns = ring_underruns + ajrf_pkg::count_type'(1);
               end
            end
            // A starved frame gives zeros throughout; so does a frame that simply
            // runs past the end of the data, but without counting an underrun.
            if (pop_starved || ring_level == 0) begin
               res.status = ajrf_pkg::STAT_UNDERRUN;
            end else begin
               res.sample_out = ring_mem[ring_rd_ptr];
               ring_rd_ptr = ajrf_pkg::ptr_next(ring_rd_ptr);
               ring_level  = ring_level - 1;
            end
         end
         ajrf_pkg::OP_TUNE: begin
            if (tune_enable_copy) begin
               if (ring_level > int'(high_mark)) begin
                  high_mark = ajrf_pkg::level_type'(ring_level);
               end
               if (ring_level < int'(low_mark)) begin
                  low_mark = ajrf_pkg::level_type'(ring_level);
               end
            end
         end
         default: begin
         end
      endcase
      res.fill_level     = ajrf_pkg::level_type'(ring_level);
      res.overrun_total  = ring_overruns;
      res.underrun_total = ring_underruns;
      res.min_level      = low_mark;
      res.max_level      = high_mark;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH at result %0d, %s: got 0x%0h, want 0x%0h",
               results_seen, what, got, want);
      error_count = error_count + 1;
   endtask

   task automatic queue_item(input ajrf_pkg::op_type op, input ajrf_pkg::sample_type sample,
                             input len_type len, input logic first);
      audio_request_type item;
      item.opcode      = op;
      item.sample      = sample;
      item.frame_len   = len;
      item.frame_first = first;
      queued_requests.push_back(item);
      items_queued = items_queued + 1;
   endtask

   // One frame: a start item that declares the length, then continuation items
   // whose length field is random, since the block ignores it there.
   task automatic queue_frame(input ajrf_pkg::op_type op, input int count, input int len);
      queue_item(op, ajrf_pkg::sample_type'($urandom), len_type'(len), 1'b1);
      for (int i = 1; i < count; i++) begin
         queue_item(op, ajrf_pkg::sample_type'($urandom), len_type'($urandom), 1'b0);
      end
   endtask

   // Mostly well-formed frames with random content, with a share of tune and
   // idle operations, stray continuation items, oversized push frames and frames
   // whose item count disagrees with their declared length. With stop_on_full
   // set, the mix ends once several push frames have landed on a full buffer.
   task automatic queue_traffic(input int n_items, input int push_pct, input int push_max,
                                input int pop_max, input bit stop_on_full);
      int     made;
      int     full_frames;
      int     roll;
      int     len;
      int     count;
      ajrf_pkg::op_type op;
      made        = 0;
      full_frames = 0;
      while (made < n_items && !(stop_on_full && full_frames >= 8)) begin
         roll = $urandom_range(99);
         if (roll < 5) begin
            queue_item(ajrf_pkg::OP_TUNE, ajrf_pkg::sample_type'($urandom),
                       len_type'($urandom), 1'($urandom));
            made = made + 1;
         end else if (roll < 8) begin
            queue_item(ajrf_pkg::OP_NOP, ajrf_pkg::sample_type'($urandom),
                       len_type'($urandom), 1'($urandom));
            made = made + 1;
         end else if (roll < 12) begin
            op = ($urandom_range(1) == 0) ? ajrf_pkg::OP_PUSH : ajrf_pkg::OP_POP;
            queue_item(op, ajrf_pkg::sample_type'($urandom), len_type'($urandom), 1'b0);
            made = made + 1;
         end else if (roll < 15) begin
            count = $urandom_range(1, 3);
            queue_frame(ajrf_pkg::OP_PUSH, count, $urandom_range(ajrf_pkg::DEPTH + 1, 65535));
            made = made + count;
         end else begin
            if ($urandom_range(99) < push_pct) begin
               op  = ajrf_pkg::OP_PUSH;
               len = $urandom_range(1, push_max);
            end else begin
               op  = ajrf_pkg::OP_POP;
               len = $urandom_range(0, pop_max);
            end
            count = len;
            roll  = $urandom_range(9);
            if (roll == 0) begin
               count = len + $urandom_range(1, 4);
            end else if (roll == 1 && len > 1) begin
               count = $urandom_range(1, len - 1);
            end
            if (count == 0) begin
               count = 1;
            end
            queue_frame(op, count, len);
            made = made + count;
            if (op == ajrf_pkg::OP_PUSH) begin
               if (plan_level >= ajrf_pkg::DEPTH) begin
                  full_frames = full_frames + 1;
               end
               plan_level = (plan_level + count > ajrf_pkg::DEPTH) ?
                            ajrf_pkg::DEPTH : plan_level + count;
            end else if (plan_level >= len) begin
               plan_level = (plan_level > count) ? plan_level - count : 0;
            end
         end
      end
   endtask

   task automatic write_tune_enable(input logic value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tune_enable_copy = value;
   endtask

   // Every item gives exactly one result, so the block is idle once the
   // result count catches up with the number of items handed out.
   task automatic wait_until_drained;
      while (results_seen != items_queued) begin
         @(posedge clock);
      end
   endtask

   // Sender: offers the next queued item whenever the wires are free, with
   // random idle cycles. The prediction is made at the edge of acceptance.
   audio_request_type on_the_wire;
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid       <= 1'b0;
         req_chan.opcode      <= '0;
         req_chan.sample_in   <= '0;
         req_chan.frame_len   <= '0;
         req_chan.frame_first <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            awaited_results.push_back(predict_ring_result(on_the_wire));
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_the_wire = queued_requests.pop_front();
               req_chan.opcode      <= on_the_wire.opcode;
               req_chan.sample_in   <= on_the_wire.sample;
               req_chan.frame_len   <= on_the_wire.frame_len;
               req_chan.frame_first <= on_the_wire.frame_first;
               req_chan.valid       <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Counts down the one long hold-off of the result side.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_arm && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Receiver: random stalls, and held off throughout the long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Checks every accepted result against the oldest prediction.
   always @(posedge clock) begin : check_results
      audio_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen <= results_seen + 1;
         if (awaited_results.size() == 0) begin
            report_mismatch("result with nothing awaited", 32'(rsp_chan.fill_level), '0);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_chan.sample_out !== want.sample_out)
               report_mismatch("sample_out",
                               32'(ajrf_pkg::sample_type'(rsp_chan.sample_out)),
                               32'(want.sample_out));
            if (rsp_chan.status !== want.status)
               report_mismatch("status", 32'(rsp_chan.status), 32'(want.status));
            if (rsp_chan.fill_level !== want.fill_level)
               report_mismatch("fill_level", 32'(rsp_chan.fill_level),
                               32'(want.fill_level));
            if (rsp_chan.overrun_total !== want.overrun_total)
               report_mismatch("overrun_total", rsp_chan.overrun_total, want.overrun_total);
            if (rsp_chan.underrun_total !== want.underrun_total)
               report_mismatch("underrun_total", rsp_chan.underrun_total,
                               want.underrun_total);
            if (rsp_chan.min_level !== want.min_level)
               report_mismatch("min_level", 32'(rsp_chan.min_level), 32'(want.min_level));
            if (rsp_chan.max_level !== want.max_level)
               report_mismatch("max_level", 32'(rsp_chan.max_level), 32'(want.max_level));
         end
      end
   end

   // Ends a hung run: too many cycles in a row without any handshake.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles, %0d of %0d results seen",
                  quiet_cycles, results_seen, items_queued);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      csr_write_enable     = 1'b0;
      csr_write_data       = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part, tuning on. Right after reset the frame flags read as an
      // accepted, not starved frame, so stray push and pop items just work.
      write_tune_enable(1'b1);
      queue_item(ajrf_pkg::OP_PUSH, 16'h1234, 16'd0, 1'b0);
      queue_item(ajrf_pkg::OP_POP, 16'h0000, 16'd0, 1'b0);
      queue_item(ajrf_pkg::OP_TUNE, 16'h0000, 16'd0, 1'b0);
      // An empty buffer: a pop frame of length zero is not starved but still
      // finds nothing, then a frame of length one starves and stays starved.
      queue_item(ajrf_pkg::OP_POP, 16'h0000, 16'd0, 1'b1);
      queue_item(ajrf_pkg::OP_POP, 16'h0000, 16'd1, 1'b1);
      queue_item(ajrf_pkg::OP_POP, 16'hffff, 16'hffff, 1'b0);
      // Sample extremes, with one item past the declared frame length.
      queue_item(ajrf_pkg::OP_PUSH, 16'h7fff, 16'd3, 1'b1);
      queue_item(ajrf_pkg::OP_PUSH, 16'h8000, 16'h0000, 1'b0);
      queue_item(ajrf_pkg::OP_PUSH, 16'h0000, 16'hffff, 1'b0);
      queue_item(ajrf_pkg::OP_PUSH, 16'hffff, 16'h0000, 1'b0);
      // Oversized frames are dropped whole; exactly the depth is allowed.
      queue_item(ajrf_pkg::OP_PUSH, 16'h0f0f, 16'hffff, 1'b1);
      queue_item(ajrf_pkg::OP_PUSH, 16'hf0f0, 16'h0000, 1'b0);
      queue_item(ajrf_pkg::OP_PUSH, 16'h0101, len_type'(ajrf_pkg::DEPTH + 1), 1'b1);
      queue_item(ajrf_pkg::OP_PUSH, 16'h5555, len_type'(ajrf_pkg::DEPTH), 1'b1);
      queue_item(ajrf_pkg::OP_TUNE, 16'hffff, 16'hffff, 1'b1);
      queue_item(ajrf_pkg::OP_POP, 16'h0000, 16'd5, 1'b1);
      for (int i = 0; i < 4; i++) begin
         queue_item(ajrf_pkg::OP_POP, 16'haaaa, 16'h5555, 1'b0);
      end
      // Running past the end of a frame that was not starved.
      queue_item(ajrf_pkg::OP_POP, 16'h0000, 16'h0000, 1'b0);
      queue_item(ajrf_pkg::OP_NOP, 16'hffff, 16'hffff, 1'b1);
      queue_item(ajrf_pkg::OP_PUSH, 16'h2468, 16'd0, 1'b1);
      queue_item(ajrf_pkg::OP_POP, 16'h0000, 16'hffff, 1'b1);
      queue_item(ajrf_pkg::OP_TUNE, 16'h0000, 16'h0000, 1'b0);
      plan_level = 1;
      wait_until_drained();

      // Balanced traffic at full rate, tuning off. The result side holds off
      // for a long stretch at the start so the input stalls.
      write_tune_enable(1'b0);
      hold_arm <= 1'b1;
      queue_traffic(200, 50, 16, 16, 1'b0);
      wait_until_drained();

      // Fill until the buffer saturates and several frames overrun, with a
      // mostly idle sender.
      write_tune_enable(1'b1);
      send_idle_pct <= 82;
      queue_traffic(1300, 85, 64, 8, 1'b1);
      wait_until_drained();

      // Drain with long pop frames while the receiver stalls most cycles.
      write_tune_enable(1'b0);
      send_idle_pct  <= 0;
      recv_stall_pct <= 82;
      queue_traffic(200, 20, 8, 64, 1'b0);
      wait_until_drained();

      // Mixed traffic with both sides idling now and then.
      write_tune_enable(1'b1);
      send_idle_pct  <= 29;
      recv_stall_pct <= 29;
      queue_traffic(100, 50, 16, 16, 1'b0);
      wait_until_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0) begin
         report_mismatch("results never delivered", 32'(awaited_results.size()), 32'd0);
      end
      $display("Covered %0d items in directed, full-rate, fill, drain and mixed phases.",
               items_queued);
      $display("Final level %0d, %0d overrun frames, %0d underruns, tune range %0d to %0d.",
               ring_level, ring_overruns, ring_underruns, low_mark, high_mark);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== audio_jitter_ring_fifo.f =====
+incdir+rtl
rtl/ajrf_pkg.sv
rtl/ajrf_req_if.sv
rtl/ajrf_rsp_if.sv
rtl/ajrf_ram.sv
rtl/audio_jitter_ring_fifo.sv
dv/audio_jitter_ring_fifo_test.sv
